// ===== hw/rtl/bcat_pkg.sv =====
// package for the block cyclic address translator
// shared widths, status codes, kind codes and the front-to-back queue entry
`timescale 1ns / 1ps
`default_nettype none
package bcat_pkg;
	localparam int TABLE_ROWS_DEF      = 1024;
	localparam int MAX_RANKS_DEF       = 1024;
	localparam int LOCAL_ADDR_BITS_DEF = 48;

	localparam int OFFSET_W  = 64;
	localparam int ID_W      = 32;
	localparam int BSIZE_W   = 32;
	localparam int MAPBASE_W = 48;
	localparam int STATUS_W  = 3;
	localparam int OWNER_W   = 10;
	localparam int LOCAL_W   = 48;
	localparam int NRANKS_W  = 11;
	localparam int MYRANK_W  = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_RANKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MY_RANK   = 1'd1;

	localparam logic KIND_TRANSLATE = 1'b0;
	localparam logic KIND_MAP       = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

	// classified item handed from the front to the back
	typedef struct packed {
		logic                 is_map;
		logic                 zero_size;
		logic                 owned;
		logic                 in_range;
		logic [OWNER_W-1:0]   owner;
		logic [ID_W-1:0]      block;
		logic [31:0]          row;
		logic [BSIZE_W-1:0]   rem;
		logic [MAPBASE_W-1:0] map_base;
	} work_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bcat_if.sv =====
// valid/ready channel interfaces for the translator
// depends on bcat_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface bcat_req_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [bcat_pkg::OFFSET_W-1:0]  offset;
	logic [bcat_pkg::ID_W-1:0]      base_id;
	logic [bcat_pkg::BSIZE_W-1:0]   blk_size;
	logic [bcat_pkg::MAPBASE_W-1:0] map_base;
	modport source (output valid, kind, offset, base_id, blk_size, map_base, input ready);
	modport sink (input valid, kind, offset, base_id, blk_size, map_base, output ready);
endinterface

interface bcat_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bcat_pkg::STATUS_W-1:0] status;
	logic [bcat_pkg::OWNER_W-1:0]  owner;
	logic [bcat_pkg::ID_W-1:0]     block_number;
	logic [bcat_pkg::LOCAL_W-1:0]  local_addr;
	modport source (output valid, status, owner, block_number, local_addr, input ready);
	modport sink (input valid, status, owner, block_number, local_addr, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bcat_front.sv =====
// front: accepts items and classifies them with a radix-2 iterative divider
// 64/32 division for block id, then 32/11 division by the rank count; uses bcat_pkg
`timescale 1ns / 1ps
`default_nettype none
module bcat_front #(
	parameter int TABLE_ROWS = bcat_pkg::TABLE_ROWS_DEF,
	parameter int MAX_RANKS  = bcat_pkg::MAX_RANKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bcat_req_if.sink                           req,
	input  wire logic [bcat_pkg::NRANKS_W-1:0] num_ranks,
	input  wire logic [bcat_pkg::MYRANK_W-1:0] my_rank,
	output logic                               wr_valid,
	input  wire logic                          wr_ready,
	output bcat_pkg::work_t                    wr_data
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV1 = 2'd1;
	localparam logic [1:0] S_DIV2 = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [31:0] base_q;
	logic [31:0] rem1_q;
	logic [31:0] block_q;
	logic        is_map_q;
	logic        zero_q;
	logic [bcat_pkg::MAPBASE_W-1:0] map_q;

	logic [32:0] trial;
	logic [31:0] ranks;
	logic [31:0] block_w;

	always_comb begin
		ranks = {21'd0, num_ranks};
		if (num_ranks == '0) ranks = 32'd1;
		if ({21'd0, num_ranks} > 32'(MAX_RANKS)) ranks = 32'(MAX_RANKS);
	end

	assign trial   = {rem_q[31:0], quo_q[63]} - {1'b0, dsr_q};
	// block id: base id plus the first quotient, completed with its last bit
	assign block_w = base_q + {quo_q[30:0], ~trial[32]};
	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					state_q <= (req.blk_size == '0) ? S_DONE : S_DIV1;
					cnt_q   <= 7'd64;
				end
				S_DIV1: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= S_DIV2;
						cnt_q   <= 7'd32;
					end
				end
				S_DIV2: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) state_q <= S_DONE;
				end
				S_DONE: if (wr_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shared restoring divider: dividend shifts through quo_q, remainder in rem_q
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req.valid) begin
				quo_q    <= req.offset;
				rem_q    <= '0;
				dsr_q    <= req.blk_size;
				base_q   <= req.base_id;
				is_map_q <= req.kind;
				zero_q   <= (req.blk_size == '0);
				map_q    <= req.map_base;
			end
			S_DIV1, S_DIV2: begin
				if (state_q == S_DIV1 && cnt_q == 7'd1) begin
					// first quotient complete: start block / ranks
					rem1_q  <= trial[32] ? {rem_q[30:0], quo_q[63]} : trial[31:0];
					block_q <= block_w;
					quo_q   <= {block_w, 32'd0};
					rem_q   <= '0;
					dsr_q   <= ranks;
				end else if (!trial[32]) begin
					rem_q <= trial;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign wr_valid = (state_q == S_DONE);
	always_comb begin
		wr_data           = '0;
		wr_data.is_map    = is_map_q;
		wr_data.zero_size = zero_q;
		wr_data.map_base  = map_q;
		if (!zero_q) begin
			wr_data.block    = block_q;
			wr_data.owner    = rem_q[bcat_pkg::OWNER_W-1:0];
			wr_data.owned    = (rem_q == {23'd0, my_rank});
			// second quotient ends up in the low half after 32 shifts
			wr_data.row      = quo_q[31:0];
			wr_data.in_range = ({32'd0, quo_q[31:0]} < 64'(TABLE_ROWS));
			wr_data.rem      = rem1_q;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bcat_queue.sv =====
// two-entry queue between front and back
// depends on bcat_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none
module bcat_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_valid,
	output logic           wr_ready,
	input  bcat_pkg::work_t wr_data,
	output logic           rd_valid,
	input  wire logic      rd_ready,
	output bcat_pkg::work_t rd_data
);
	bcat_pkg::work_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bcat_back.sv =====
// back: translation table access and result register
// table is a memory with registered read, zeroed by a clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none
module bcat_back #(
	parameter int TABLE_ROWS      = bcat_pkg::TABLE_ROWS_DEF,
	parameter int LOCAL_ADDR_BITS = bcat_pkg::LOCAL_ADDR_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rd_valid,
	output logic            rd_ready,
	input  bcat_pkg::work_t rd_data,
	bcat_rsp_if.source      rsp
);
	localparam int RW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

	logic [LOCAL_ADDR_BITS-1:0] table_q [TABLE_ROWS];
	logic                       clr_q;
	logic [RW-1:0]              clr_idx_q;
	logic [LOCAL_ADDR_BITS-1:0] entry_s1;
	logic                       busy_s1;
	bcat_pkg::work_t            item_s1;
	logic                       out_q;
	logic [RW-1:0]              idx;
	logic                       take;
	logic [LOCAL_ADDR_BITS-1:0] sum;

	assign idx      = rd_data.row[RW-1:0];
	assign rd_ready = !clr_q && !busy_s1 && (!out_q || rsp.ready);
	assign take     = rd_valid && rd_ready;
	assign sum      = entry_s1 + LOCAL_ADDR_BITS'({32'd0, item_s1.rem});

	always_ff @(posedge clk) begin
		// one row per cycle is zeroed while clearing
		if (clr_q) table_q[clr_idx_q] <= '0;
		else if (take && rd_data.is_map && !rd_data.zero_size && rd_data.in_range)
			table_q[idx] <= LOCAL_ADDR_BITS'({16'd0, rd_data.map_base});
		if (take) begin
			item_s1 <= rd_data;
			if (rd_data.in_range) entry_s1 <= table_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			busy_s1   <= 1'b0;
			out_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + RW'(1);
				if (clr_idx_q == RW'(TABLE_ROWS - 1)) clr_q <= 1'b0;
			end
			busy_s1 <= take;
			if (busy_s1) out_q <= 1'b1;
			else if (rsp.ready) out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			rsp.owner        <= item_s1.owner;
			rsp.block_number <= item_s1.block;
			rsp.local_addr   <= '0;
			if (item_s1.zero_size) rsp.status <= bcat_pkg::ST_ZERO_SIZE;
			else if (item_s1.is_map)
				rsp.status <= item_s1.in_range ? bcat_pkg::ST_OK : bcat_pkg::ST_RANGE;
			else if (!item_s1.owned) rsp.status <= bcat_pkg::ST_NOT_OWNED;
			else if (!item_s1.in_range) rsp.status <= bcat_pkg::ST_RANGE;
			else if (entry_s1 == '0) rsp.status <= bcat_pkg::ST_UNMAPPED;
			else begin
				rsp.status     <= bcat_pkg::ST_OK;
				rsp.local_addr <= bcat_pkg::LOCAL_W'({16'd0, sum});
			end
		end
	end
	assign rsp.valid = out_q;
endmodule
`default_nettype wire

// ===== hw/rtl/block_cyclic_address_translator.sv =====
// Block-cyclic address translator: one item in, one result out. The front divides the
// offset by the block size and the block id by the rank count on one shared radix-2
// divider, and takes no new item until the last one has been handed on to the queue. After
// reset the back zeroes the table one row per cycle and holds off items until that is done.
`timescale 1ns / 1ps
`default_nettype none
module block_cyclic_address_translator #(
	parameter int TABLE_ROWS      = bcat_pkg::TABLE_ROWS_DEF,
	parameter int MAX_RANKS       = bcat_pkg::MAX_RANKS_DEF,
	parameter int LOCAL_ADDR_BITS = bcat_pkg::LOCAL_ADDR_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bcat_req_if.sink                            req,
	bcat_rsp_if.source                          rsp,
	input  wire logic                           cfg_we,
	input  wire logic [bcat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bcat_pkg::CFG_DAT_W-1:0] cfg_data
);
	logic [bcat_pkg::NRANKS_W-1:0] num_ranks_q;
	logic [bcat_pkg::MYRANK_W-1:0] my_rank_q;
	logic wv, wr, rv, rr;
	bcat_pkg::work_t wd, rdd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ranks_q <= 11'd1;
			my_rank_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcat_pkg::REG_NUM_RANKS: num_ranks_q <= cfg_data;
				bcat_pkg::REG_MY_RANK:   my_rank_q <= cfg_data[bcat_pkg::MYRANK_W-1:0];
				default: ;
			endcase
		end
	end

	bcat_front #(.TABLE_ROWS(TABLE_ROWS), .MAX_RANKS(MAX_RANKS)) u_front (
		.clk, .arst_n, .req, .num_ranks(num_ranks_q), .my_rank(my_rank_q),
		.wr_valid(wv), .wr_ready(wr), .wr_data(wd)
	);
	bcat_queue u_queue (
		.clk, .arst_n, .wr_valid(wv), .wr_ready(wr), .wr_data(wd),
		.rd_valid(rv), .rd_ready(rr), .rd_data(rdd)
	);
	bcat_back #(.TABLE_ROWS(TABLE_ROWS), .LOCAL_ADDR_BITS(LOCAL_ADDR_BITS)) u_back (
		.clk, .arst_n, .rd_valid(rv), .rd_ready(rr), .rd_data(rdd), .rsp
	);
endmodule
`default_nettype wire

// ===== test/tb_bcat_if.sv =====
// testbench copy point for the translator channel interfaces
// the channel interfaces themselves live with the rtl in bcat_if.sv; this file holds tb helpers
`timescale 1ns / 1ps
package tb_bcat_types;
	// one expected translator result
	typedef struct packed {
		logic [bcat_pkg::STATUS_W-1:0] status;
		logic [bcat_pkg::OWNER_W-1:0]  owner;
		logic [bcat_pkg::ID_W-1:0]     block_number;
		logic [bcat_pkg::LOCAL_W-1:0]  local_addr;
	} xlat_result_t;
endpackage

// ===== test/tb_block_cyclic_address_translator.sv =====
// testbench for the block cyclic address translator
// predicts each result in place and compares it; depends on bcat_pkg, bcat_if and tb_bcat_types
`timescale 1ns / 1ps
module tb_block_cyclic_address_translator;
	localparam int HOLD_CYCLES = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bcat_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bcat_pkg::CFG_DAT_W-1:0] cfg_data = '0;
	bcat_req_if req();
	bcat_rsp_if rsp();

	block_cyclic_address_translator dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [bcat_pkg::NRANKS_W-1:0] ranks_reg = 11'd1;
	logic [bcat_pkg::MYRANK_W-1:0] rank_reg = '0;
	logic [bcat_pkg::LOCAL_W-1:0] xlat_table [0:bcat_pkg::TABLE_ROWS_DEF-1];
	tb_bcat_types::xlat_result_t pending_results[$];
	int fail_count = 0;
	event hold_go;        // starts a long receiver hold-off
	bit rx_hold_on = 1'b0;
	bit rand_stall = 1'b0;

	function automatic tb_bcat_types::xlat_result_t translate_item(logic kind,
			logic [63:0] offset, logic [31:0] base_id, logic [31:0] bsize,
			logic [47:0] map_base);
		tb_bcat_types::xlat_result_t r;
		logic [63:0] ranks;
		logic [31:0] block;
		logic [63:0] row;
		logic [63:0] sum;
		r = '0;
		if (bsize == 0) begin
			r.status = bcat_pkg::ST_ZERO_SIZE;
			return r;
		end
		ranks = (ranks_reg == 0) ? 64'd1 : (ranks_reg > bcat_pkg::MAX_RANKS_DEF) ?
			64'(bcat_pkg::MAX_RANKS_DEF) : 64'(ranks_reg);
		block = base_id + 32'(offset / bsize);
		r.block_number = block;
		r.owner = bcat_pkg::OWNER_W'(block % ranks);
		row = block / ranks;
		r.status = bcat_pkg::ST_OK;
		if (kind == bcat_pkg::KIND_MAP) begin
			if (row < bcat_pkg::TABLE_ROWS_DEF)
				xlat_table[row] = map_base;
			else
				r.status = bcat_pkg::ST_RANGE;
		end else if (block % ranks != 64'(rank_reg)) begin
			r.status = bcat_pkg::ST_NOT_OWNED;
		end else if (row >= bcat_pkg::TABLE_ROWS_DEF) begin
			r.status = bcat_pkg::ST_RANGE;
		end else if (xlat_table[row] == 0) begin
			r.status = bcat_pkg::ST_UNMAPPED;
		end else begin
			sum = 64'(xlat_table[row]) + offset % bsize;
			r.local_addr = sum[47:0];
		end
		return r;
	endfunction

	task automatic write_reg(logic [bcat_pkg::CFG_IDX_W-1:0] idx,
			logic [bcat_pkg::CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bcat_pkg::REG_NUM_RANKS)
			ranks_reg = val;
		else
			rank_reg = val[bcat_pkg::MYRANK_W-1:0];
	endtask

	task automatic send_item(logic kind, logic [63:0] offset, logic [31:0] base_id,
			logic [31:0] bsize, logic [47:0] map_base);
		int gap;
		gap = $urandom_range(0, 3);
		if (rand_stall && gap > 0) begin
			@(posedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(posedge clk);
		end
		@(posedge clk);
		req.valid <= 1'b1;
		req.kind <= kind;
		req.offset <= offset;
		req.base_id <= base_id;
		req.blk_size <= bsize;
		req.map_base <= map_base;
		do @(posedge clk); while (!(req.valid && req.ready));
		pending_results.push_back(translate_item(kind, offset, base_id, bsize, map_base));
		if (!rand_stall)
			req.valid <= 1'b0;
	endtask

	task automatic drain_results();
		@(posedge clk);
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// long receiver hold-off, counted here
	always begin
		@(hold_go);
		rx_hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold_on <= 1'b0;
	end

	// result side: checks each result; ready is random while stalling, else high; long hold-off when asked
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			tb_bcat_types::xlat_result_t e;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status); fail_count++;
				end
				if (rsp.owner !== e.owner) begin
					$error("owner exp %0d got %0d", e.owner, rsp.owner); fail_count++;
				end
				if (rsp.block_number !== e.block_number) begin
					$error("block_number exp %h got %h", e.block_number, rsp.block_number);
					fail_count++;
				end
				if (rsp.local_addr !== e.local_addr) begin
					$error("local_addr exp %h got %h", e.local_addr, rsp.local_addr);
					fail_count++;
				end
			end
		end
		if (rx_hold_on)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= rand_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		// rank count 1, rank 0: zero size, map then hit
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd0, 32'd0, 32'd0, 48'd0);
		send_item(bcat_pkg::KIND_MAP, 64'd0, 32'd0, 32'd1, 48'hFFFF_FFFF_FFFF);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd0, 32'd0, 32'd1, 48'd0);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd1, 32'd0, 32'd1, 48'd0);
		send_item(bcat_pkg::KIND_MAP, 64'd100, 32'd1, 32'd16, 48'h1000);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd111, 32'd1, 32'd16, 48'd0);
		// wrap of block id, offset extremes, last table row and a row out of range
		send_item(bcat_pkg::KIND_TRANSLATE, '1, '1, '1, '1);
		send_item(bcat_pkg::KIND_MAP, '1, 32'd0, 32'd1, 48'd5);
		send_item(bcat_pkg::KIND_TRANSLATE, '1, 32'd0, 32'd1, 48'd0);
		send_item(bcat_pkg::KIND_MAP, 64'd0, 32'd1023, 32'd4, 48'hFFFF_FFFF_FFFF);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd3, 32'd1023, 32'd4, 48'd0);
		send_item(bcat_pkg::KIND_MAP, 64'd0, 32'd1023, 32'd4, 48'd0);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd3, 32'd1023, 32'd4, 48'd0);
		send_item(bcat_pkg::KIND_MAP, 64'd0, 32'd1024, 32'd4, 48'd7);
		drain_results();
		// rank count out of range, not owned
		write_reg(bcat_pkg::REG_NUM_RANKS, 11'd0);
		write_reg(bcat_pkg::REG_MY_RANK, 11'd1023);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd0, 32'd5, 32'd8, 48'd0);
		drain_results();
		write_reg(bcat_pkg::REG_NUM_RANKS, 11'h7FF);
		send_item(bcat_pkg::KIND_MAP, 64'd0, 32'd2047, 32'd8, 48'h42);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd7, 32'd2047, 32'd8, 48'd0);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd7, 32'd2046, 32'd8, 48'd0);
		send_item(bcat_pkg::KIND_TRANSLATE, 64'd0, 32'hFFFF_FFFF, 32'd1, 48'd0);
		drain_results();
	endtask

	task automatic test_random(int n);
		int rows;
		logic [31:0] bsize;
		logic [63:0] offset;
		logic [31:0] base_id;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) begin
				drain_results();
				write_reg(bcat_pkg::REG_NUM_RANKS, (i % 400 == 0) ?
					bcat_pkg::CFG_DAT_W'($urandom_range(1, 8))
					: bcat_pkg::CFG_DAT_W'($urandom_range(0, 2047)));
				write_reg(bcat_pkg::REG_MY_RANK,
					bcat_pkg::CFG_DAT_W'($urandom_range(0, ranks_reg > 1 ? 3 : 0)));
			end
			rows = (ranks_reg == 0) ? 1 : ranks_reg;
			case ($urandom_range(0, 9))
				0: bsize = $urandom();
				1: bsize = 32'd0;
				default: bsize = 32'(1) << $urandom_range(0, 31);
			endcase
			if (bsize == 0) bsize = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1;
			base_id = ($urandom_range(0, 4) == 0) ? $urandom()
				: 32'($urandom_range(0, rows * 1100 > 0 ? rows * 1100 : 1100));
			offset = ($urandom_range(0, 4) == 0) ? rand64() : 64'(bsize) * $urandom_range(0, 4)
				+ (bsize != 0 ? rand64() % bsize : 64'd0);
			send_item(1'($urandom_range(0, 2) == 0), offset, base_id, bsize,
				($urandom_range(0, 9) == 0) ? 48'd0 : 48'(rand64()));
		end
	endtask

	task automatic test_backpressure();
		-> hold_go;
		for (int i = 0; i < 12; i++)
			send_item(bcat_pkg::KIND_TRANSLATE, rand64(), $urandom(),
				32'($urandom_range(1, 1000)), 48'd0);
		drain_results();
	endtask

	initial begin
		req.valid = 1'b0;
		req.kind = bcat_pkg::KIND_TRANSLATE;
		req.offset = '0;
		req.base_id = '0;
		req.blk_size = '0;
		req.map_base = '0;
		for (int i = 0; i < bcat_pkg::TABLE_ROWS_DEF; i++)
			xlat_table[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		rand_stall = 1'b1;
		test_random(400);
		rand_stall = 1'b0;
		test_random(200);
		rand_stall = 1'b1;
		test_backpressure();
		test_random(200);
		drain_results();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
